FILE: rtl/rrd_pkg.sv
// Shared constants and controller/datapath command and status types
// for the radial RLE packet decoder. No dependencies.
package rrd_pkg;

  localparam logic [7:0] CODE_HIGH = 8'd175;
  localparam logic [7:0] CODE_LOW  = 8'd31;
  localparam logic [3:0] HDR_LAST  = 4'd9;

  typedef struct packed {
    logic rst_all;
    logic out_err;
    logic out_bin;
    logic out_last;
    logic bin_src_em;
    logic hdr_clr;
    logic hdr_inc;
    logic hold_ld;
    logic radials_ld;
    logic run_ld;
    logic sa_ld;
    logic ad_ld;
    logic end_radial;
    logic run_dec;
    logic em_ld;
    logic em_dec;
  } rrd_cmd_t;

  typedef struct packed {
    logic       code_hi_ok;
    logic       code_lo_ok;
    logic       hw_pos;
    logic       hdr_done;
    logic       run_last;
    logic       run_zero;
    logic       rad_last;
    logic       out_free;
    logic       em_last;
    logic [3:0] run_len;
  } rrd_sts_t;

endpackage

FILE: rtl/rrd_if.sv
// Valid/ready channel interfaces for packet bytes and decoded results.
// No dependencies.
interface rrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_packet;

  modport source (output valid, output data_byte, output start_of_packet, input ready);
  modport sink   (input valid, input data_byte, input start_of_packet, output ready);
endinterface

interface rrd_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         bin_value;
  logic [14:0]        radial_number;
  logic signed [15:0] az_start;
  logic signed [15:0] az_span;
  logic [15:0]        bin_position;
  logic               last_of_run;

  modport source (output valid, output kind, output bin_value, output radial_number,
                  output az_start, output az_span, output bin_position,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input bin_value, input radial_number,
                  input az_start, input az_span, input bin_position,
                  input last_of_run, output ready);
endinterface

FILE: rtl/radial_rle_packet_decoder_core.sv
// Radial RLE packet decoder top level. A result appears in the cycle after
// the byte that causes it is accepted. Throughput: one byte per cycle unless
// the output stalls, except a run byte with run length L > 1 (up to 15), which
// holds the input while the single result register emits one bin per cycle unless stalled.
// Reset: synchronous active-low rst_n; decoder returns to waiting for start.
module radial_rle_packet_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  rrd_in_if.sink     in_ch,
  rrd_out_if.source  out_ch
);
  import rrd_pkg::*;

  rrd_cmd_t cmd;
  rrd_sts_t sts;
  logic     in_ready;

  rrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_start (in_ch.start_of_packet),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_ch.data_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_kind          (out_ch.kind),
    .out_bin_value     (out_ch.bin_value),
    .out_radial_number (out_ch.radial_number),
    .out_az_start      (out_ch.az_start),
    .out_az_span       (out_ch.az_span),
    .out_bin_position  (out_ch.bin_position),
    .out_last_of_run   (out_ch.last_of_run)
  );

  assign in_ch.ready = in_ready;

endmodule

FILE: rtl/rrd_ctrl.sv
// Packet parse controller: phase state machine and run expansion sequencing.
// Depends on rrd_pkg.
module rrd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_start,
  output logic              in_ready,
  input  rrd_pkg::rrd_sts_t sts,
  output rrd_pkg::rrd_cmd_t cmd
);
  import rrd_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CODE_LOW = 4'd1;
  localparam logic [3:0] ST_HEADER   = 4'd2;
  localparam logic [3:0] ST_COUNT_HI = 4'd3;
  localparam logic [3:0] ST_COUNT_LO = 4'd4;
  localparam logic [3:0] ST_RLE_HI   = 4'd5;
  localparam logic [3:0] ST_RLE_LO   = 4'd6;
  localparam logic [3:0] ST_SA_HI    = 4'd7;
  localparam logic [3:0] ST_SA_LO    = 4'd8;
  localparam logic [3:0] ST_AD_HI    = 4'd9;
  localparam logic [3:0] ST_AD_LO    = 4'd10;
  localparam logic [3:0] ST_RUN      = 4'd11;
  localparam logic [3:0] ST_EMIT     = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       fin;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    fin       = 1'b0;
    in_ready  = (state_r != ST_EMIT) && sts.out_free;
    if (state_r == ST_EMIT) begin
      if (sts.out_free) begin
        cmd.out_bin    = 1'b1;
        cmd.bin_src_em = 1'b1;
        cmd.out_last   = sts.em_last;
        cmd.em_dec     = 1'b1;
        fin            = sts.em_last;
      end
    end else if (in_valid && in_ready) begin
      if (in_start) begin
        cmd.rst_all = 1'b1;
        if (sts.code_hi_ok) begin
          state_nxt = ST_CODE_LOW;
        end else begin
          cmd.out_err = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end else begin
        case (state_r)
          ST_IDLE: begin
            state_nxt = ST_IDLE;
          end
          ST_CODE_LOW: begin
            if (sts.code_lo_ok) begin
              cmd.hdr_clr = 1'b1;
              state_nxt   = ST_HEADER;
            end else begin
              cmd.out_err = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          ST_HEADER: begin
            if (sts.hdr_done) begin
              cmd.hdr_clr = 1'b1;
              state_nxt   = ST_COUNT_HI;
            end else begin
              cmd.hdr_inc = 1'b1;
            end
          end
          ST_COUNT_HI: begin
            cmd.hold_ld = 1'b1;
            state_nxt   = ST_COUNT_LO;
          end
          ST_COUNT_LO: begin
            if (sts.hw_pos) begin
              cmd.radials_ld = 1'b1;
              state_nxt      = ST_RLE_HI;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_RLE_HI: begin
            cmd.hold_ld = 1'b1;
            state_nxt   = ST_RLE_LO;
          end
          ST_RLE_LO: begin
            cmd.run_ld = 1'b1;
            state_nxt  = ST_SA_HI;
          end
          ST_SA_HI: begin
            cmd.hold_ld = 1'b1;
            state_nxt   = ST_SA_LO;
          end
          ST_SA_LO: begin
            cmd.sa_ld = 1'b1;
            state_nxt = ST_AD_HI;
          end
          ST_AD_HI: begin
            cmd.hold_ld = 1'b1;
            state_nxt   = ST_AD_LO;
          end
          ST_AD_LO: begin
            cmd.ad_ld = 1'b1;
            if (sts.run_zero) begin
              cmd.end_radial = 1'b1;
              state_nxt      = sts.rad_last ? ST_IDLE : ST_RLE_HI;
            end else begin
              state_nxt = ST_RUN;
            end
          end
          ST_RUN: begin
            if (sts.run_len == 4'd0) begin
              fin = 1'b1;
            end else begin
              cmd.out_bin  = 1'b1;
              cmd.out_last = (sts.run_len == 4'd1);
              if (sts.run_len == 4'd1) begin
                fin = 1'b1;
              end else begin
                cmd.em_ld = 1'b1;
                state_nxt = ST_EMIT;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
    if (fin) begin
      cmd.run_dec = 1'b1;
      if (sts.run_last) begin
        cmd.end_radial = 1'b1;
        state_nxt      = sts.rad_last ? ST_IDLE : ST_RLE_HI;
      end else begin
        state_nxt = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rrd_dp.sv
// Decoder datapath: header/count/angle registers, bin counter, run expansion
// registers and the result output register. Depends on rrd_pkg.
module rrd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  rrd_pkg::rrd_cmd_t  cmd,
  output rrd_pkg::rrd_sts_t  sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_kind,
  output logic [3:0]         out_bin_value,
  output logic [14:0]        out_radial_number,
  output logic signed [15:0] out_az_start,
  output logic signed [15:0] out_az_span,
  output logic [15:0]        out_bin_position,
  output logic               out_last_of_run
);
  import rrd_pkg::*;

  logic [3:0]  hdr_r, hdr_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] radials_r, radials_nxt;
  logic [16:0] run_r, run_nxt;
  logic [14:0] rad_cnt_r, rad_cnt_nxt;
  logic [15:0] sa_r, sa_nxt;
  logic [15:0] ad_r, ad_nxt;
  logic [15:0] bin_r, bin_nxt;
  logic [3:0]  em_val_r, em_val_nxt;
  logic [3:0]  em_left_r, em_left_nxt;
  logic        ov_r, ov_nxt;
  logic        ok_r, ok_nxt;
  logic [3:0]  oval_r, oval_nxt;
  logic [14:0] orad_r, orad_nxt;
  logic [15:0] osa_r, osa_nxt;
  logic [15:0] oad_r, oad_nxt;
  logic [15:0] opos_r, opos_nxt;
  logic        olast_r, olast_nxt;
  logic [15:0] hw;
  logic        hw_pos;

  assign hw     = {hold_r, in_byte};
  assign hw_pos = (hw != 16'd0) && !hw[15];

  always_comb begin
    sts.code_hi_ok = (in_byte == CODE_HIGH);
    sts.code_lo_ok = (in_byte == CODE_LOW);
    sts.hw_pos     = hw_pos;
    sts.hdr_done   = (hdr_r == HDR_LAST);
    sts.run_last   = (run_r == 17'd1);
    sts.run_zero   = (run_r == 17'd0);
    sts.rad_last   = (radials_r == 16'd1);
    sts.out_free   = !ov_r || out_ready;
    sts.em_last    = (em_left_r == 4'd1);
    sts.run_len    = in_byte[7:4];
  end

  always_comb begin
    hdr_nxt     = hdr_r;
    hold_nxt    = hold_r;
    radials_nxt = radials_r;
    run_nxt     = run_r;
    rad_cnt_nxt = rad_cnt_r;
    sa_nxt      = sa_r;
    ad_nxt      = ad_r;
    bin_nxt     = bin_r;
    em_val_nxt  = em_val_r;
    em_left_nxt = em_left_r;
    ov_nxt      = ov_r;
    ok_nxt      = ok_r;
    oval_nxt    = oval_r;
    orad_nxt    = orad_r;
    osa_nxt     = osa_r;
    oad_nxt     = oad_r;
    opos_nxt    = opos_r;
    olast_nxt   = olast_r;

    if (cmd.hdr_clr) begin
      hdr_nxt = 4'd0;
    end else if (cmd.hdr_inc) begin
      hdr_nxt = hdr_r + 4'd1;
    end
    if (cmd.hold_ld) begin
      hold_nxt = in_byte;
    end
    if (cmd.radials_ld) begin
      radials_nxt = hw;
      rad_cnt_nxt = '0;
      bin_nxt     = '0;
    end
    if (cmd.run_ld) begin
      run_nxt = hw_pos ? {hw, 1'b0} : 17'd0;
    end
    if (cmd.sa_ld) begin
      sa_nxt = hw;
    end
    if (cmd.ad_ld) begin
      ad_nxt  = hw;
      bin_nxt = '0;
    end
    if (cmd.em_ld) begin
      em_val_nxt  = in_byte[3:0];
      em_left_nxt = in_byte[7:4] - 4'd1;
    end else if (cmd.em_dec) begin
      em_left_nxt = em_left_r - 4'd1;
    end

    if (cmd.out_err) begin
      ov_nxt    = 1'b1;
      ok_nxt    = 1'b1;
      oval_nxt  = '0;
      orad_nxt  = '0;
      osa_nxt   = '0;
      oad_nxt   = '0;
      opos_nxt  = '0;
      olast_nxt = 1'b1;
    end else if (cmd.out_bin) begin
      ov_nxt    = 1'b1;
      ok_nxt    = 1'b0;
      oval_nxt  = cmd.bin_src_em ? em_val_r : in_byte[3:0];
      orad_nxt  = rad_cnt_r;
      osa_nxt   = sa_r;
      oad_nxt   = ad_r;
      opos_nxt  = bin_r;
      olast_nxt = cmd.out_last;
      if (bin_r != 16'hFFFF) begin
        bin_nxt = bin_r + 16'd1;
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end

    if (cmd.run_dec) begin
      run_nxt = run_r - 17'd1;
    end
    if (cmd.end_radial) begin
      rad_cnt_nxt = rad_cnt_r + 15'd1;
      radials_nxt = radials_r - 16'd1;
      bin_nxt     = '0;
      run_nxt     = '0;
    end
    if (cmd.rst_all) begin
      hdr_nxt     = '0;
      hold_nxt    = '0;
      radials_nxt = '0;
      run_nxt     = '0;
      rad_cnt_nxt = '0;
      sa_nxt      = '0;
      ad_nxt      = '0;
      bin_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= '0;
      hold_r    <= '0;
      radials_r <= '0;
      run_r     <= '0;
      rad_cnt_r <= '0;
      sa_r      <= '0;
      ad_r      <= '0;
      bin_r     <= '0;
      em_left_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      hdr_r     <= hdr_nxt;
      hold_r    <= hold_nxt;
      radials_r <= radials_nxt;
      run_r     <= run_nxt;
      rad_cnt_r <= rad_cnt_nxt;
      sa_r      <= sa_nxt;
      ad_r      <= ad_nxt;
      bin_r     <= bin_nxt;
      em_left_r <= em_left_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_val_r <= em_val_nxt;
    ok_r     <= ok_nxt;
    oval_r   <= oval_nxt;
    orad_r   <= orad_nxt;
    osa_r    <= osa_nxt;
    oad_r    <= oad_nxt;
    opos_r   <= opos_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_bin_value     = oval_r;
  assign out_radial_number = orad_r;
  assign out_az_start      = osa_r;
  assign out_az_span       = oad_r;
  assign out_bin_position  = opos_r;
  assign out_last_of_run   = olast_r;

endmodule

FILE: rtl/rrd_checker.sv
// Port-level checker for the radial RLE packet decoder, bound to the top.
// Depends on radial_rle_packet_decoder_core and the channel interfaces.
module rrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [3:0]  out_bin_value,
  input logic [14:0] out_radial_number,
  input logic [15:0] out_az_start,
  input logic [15:0] out_az_span,
  input logic [15:0] out_bin_position,
  input logic        out_last_of_run
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_bin_value == 4'd0 && out_radial_number == 15'd0 &&
      out_az_start == 16'd0 && out_az_span == 16'd0 &&
      out_bin_position == 16'd0 && out_last_of_run)
    else $error("error transaction carries nonzero fields");

  a_err_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("error transaction without an accepted byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_bin_value) && $stable(out_bin_position) && $stable(out_last_of_run))
    else $error("stalled result transaction changed");

endmodule

bind radial_rle_packet_decoder_core rrd_checker u_rrd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_bin_value     (out_ch.bin_value),
  .out_radial_number (out_ch.radial_number),
  .out_az_start      (out_ch.az_start),
  .out_az_span       (out_ch.az_span),
  .out_bin_position  (out_ch.bin_position),
  .out_last_of_run   (out_ch.last_of_run)
);
